// ===== src/fade_ctl_pkg.sv =====
// ----------------------------------------------------------------------------
// fade_ctl_pkg
// Shared constants and codes for the overlay fade controller.
// ----------------------------------------------------------------------------
package fade_ctl_pkg;

    localparam logic [7:0] FADE_STEPS = 8'd8;

    localparam logic [9:0]  FADE_PERIOD_RST = 10'd50;
    localparam logic [13:0] SHORT_HOLD_RST  = 14'd5000;
    localparam logic [13:0] LONG_HOLD_RST   = 14'd10000;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_TOGGLE  = 2'd1,
        CMD_RESTORE = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        MODE_SHORT    = 2'd0,
        MODE_LONG     = 2'd1,
        MODE_FOREVER  = 2'd2,
        MODE_DISABLED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_FADE_PERIOD   = 2'd0,
        REG_DURATION_MODE = 2'd1,
        REG_SHORT_HOLD    = 2'd2,
        REG_LONG_HOLD     = 2'd3
    } reg_index_t;

endpackage

// ===== src/fade_in_hold_fade_out_controller.sv =====
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_ready is high; the result register frees as it is taken.
// All state updates in one pass of logic between the state and result regs.
// Reset: asynchronous, active low; state cleared, registers to defaults.
// ----------------------------------------------------------------------------
// fade_in_hold_fade_out_controller
// Overlay fade level sequencer with fade timer, hold timer and APB registers.
// ----------------------------------------------------------------------------
module fade_in_hold_fade_out_controller
    import fade_ctl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic        saved_visible,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  fade_level,
    output logic        visible,
    output logic        save_valid,
    output logic        save_value,
    output logic        redraw
);

    logic [9:0]  fade_period_reg;
    logic [1:0]  duration_mode_reg;
    logic [13:0] short_hold_reg;
    logic [13:0] long_hold_reg;

    logic [7:0]  level_reg, level_next;
    logic        rising_reg, rising_next;
    logic        falling_reg, falling_next;
    logic [9:0]  step_count_reg, step_count_next;
    logic        step_armed_reg, step_armed_next;
    logic [13:0] hold_count_reg, hold_count_next;
    logic        hold_armed_reg, hold_armed_next;

    logic        out_valid_reg;
    logic [7:0]  fade_level_reg;
    logic        visible_reg;
    logic        save_valid_reg, save_valid_next;
    logic        save_value_reg, save_value_next;
    logic        redraw_reg, redraw_next;

    logic        cfg_write;
    reg_index_t  cfg_index;
    logic        accept;
    logic [9:0]  step_load;
    logic [13:0] hold_load;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_index)
            REG_FADE_PERIOD:   prdata = {22'd0, fade_period_reg};
            REG_DURATION_MODE: prdata = {30'd0, duration_mode_reg};
            REG_SHORT_HOLD:    prdata = {18'd0, short_hold_reg};
            REG_LONG_HOLD:     prdata = {18'd0, long_hold_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // zero period or hold behaves as one
    assign step_load = (fade_period_reg == 10'd0) ? 10'd1 : fade_period_reg;

    always_comb
    begin
        logic [13:0] t;
        t = (duration_mode_reg == MODE_SHORT) ? short_hold_reg : long_hold_reg;
        hold_load = (t == 14'd0) ? 14'd1 : t;
    end

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        logic step_fire;
        logic hold_fire;
        level_next      = level_reg;
        rising_next     = rising_reg;
        falling_next    = falling_reg;
        step_count_next = step_count_reg;
        step_armed_next = step_armed_reg;
        hold_count_next = hold_count_reg;
        hold_armed_next = hold_armed_reg;
        save_valid_next = 1'b0;
        save_value_next = 1'b0;
        redraw_next     = 1'b0;
        step_fire       = 1'b0;
        hold_fire       = 1'b0;

        case (command_t'(command))
            CMD_TICK:
            begin
                if (step_armed_reg)
                begin
                    if (step_count_reg <= 10'd1)
                    begin
                        step_armed_next = 1'b0;
                        step_count_next = 10'd0;
                        step_fire       = 1'b1;
                    end
                    else
                    begin
                        step_count_next = step_count_reg - 10'd1;
                    end
                end
                if (hold_armed_reg)
                begin
                    if (hold_count_reg <= 14'd1)
                    begin
                        hold_armed_next = 1'b0;
                        hold_count_next = 14'd0;
                        hold_fire       = 1'b1;
                    end
                    else
                    begin
                        hold_count_next = hold_count_reg - 14'd1;
                    end
                end
                if (step_fire)
                begin
                    if (rising_reg)
                    begin
                        if (level_reg + 8'd1 >= FADE_STEPS)
                        begin
                            level_next  = FADE_STEPS;
                            rising_next = 1'b0;
                            if (duration_mode_reg != MODE_FOREVER)
                            begin
                                hold_count_next = hold_load;
                                hold_armed_next = 1'b1;
                            end
                        end
                        else
                        begin
                            level_next      = level_reg + 8'd1;
                            step_count_next = step_load;
                            step_armed_next = 1'b1;
                        end
                    end
                    else if (falling_reg)
                    begin
                        if (level_reg <= 8'd1)
                        begin
                            level_next   = 8'd0;
                            falling_next = 1'b0;
                        end
                        else
                        begin
                            level_next      = level_reg - 8'd1;
                            step_count_next = step_load;
                            step_armed_next = 1'b1;
                        end
                    end
                    redraw_next = 1'b1;
                end
                if (hold_fire)
                begin
                    falling_next    = 1'b1;
                    rising_next     = 1'b0;
                    step_count_next = step_load;
                    step_armed_next = 1'b1;
                    save_valid_next = 1'b1;
                end
            end
            CMD_TOGGLE:
            begin
                hold_armed_next = 1'b0;
                hold_count_next = 14'd0;
                if ((level_reg != 8'd0) && !rising_reg)
                begin
                    rising_next  = 1'b0;
                    falling_next = 1'b1;
                end
                else
                begin
                    falling_next    = 1'b0;
                    rising_next     = 1'b1;
                    save_value_next = 1'b1;
                end
                step_count_next = step_load;
                step_armed_next = 1'b1;
                save_valid_next = 1'b1;
            end
            CMD_RESTORE:
            begin
                if ((duration_mode_reg != MODE_DISABLED) && saved_visible)
                begin
                    level_next      = FADE_STEPS;
                    rising_next     = 1'b0;
                    falling_next    = 1'b0;
                    step_armed_next = 1'b0;
                    step_count_next = 10'd0;
                    hold_armed_next = 1'b0;
                    hold_count_next = 14'd0;
                    if (duration_mode_reg != MODE_FOREVER)
                    begin
                        hold_count_next = hold_load;
                        hold_armed_next = 1'b1;
                    end
                    redraw_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_period_reg   <= FADE_PERIOD_RST;
            duration_mode_reg <= MODE_SHORT;
            short_hold_reg    <= SHORT_HOLD_RST;
            long_hold_reg     <= LONG_HOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FADE_PERIOD:   fade_period_reg   <= pwdata[9:0];
                REG_DURATION_MODE: duration_mode_reg <= pwdata[1:0];
                REG_SHORT_HOLD:    short_hold_reg    <= pwdata[13:0];
                REG_LONG_HOLD:     long_hold_reg     <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 8'd0;
            rising_reg     <= 1'b0;
            falling_reg    <= 1'b0;
            step_count_reg <= 10'd0;
            step_armed_reg <= 1'b0;
            hold_count_reg <= 14'd0;
            hold_armed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                level_reg      <= level_next;
                rising_reg     <= rising_next;
                falling_reg    <= falling_next;
                step_count_reg <= step_count_next;
                step_armed_reg <= step_armed_next;
                hold_count_reg <= hold_count_next;
                hold_armed_reg <= hold_armed_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fade_level_reg <= level_next;
            visible_reg    <= (level_next != 8'd0);
            save_valid_reg <= save_valid_next;
            save_value_reg <= save_value_next;
            redraw_reg     <= redraw_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fade_level = fade_level_reg;
    assign visible    = visible_reg;
    assign save_valid = save_valid_reg;
    assign save_value = save_value_reg;
    assign redraw     = redraw_reg;

endmodule
